FILE: rtl/fnvw_pkg.sv
// Shared constants and types for the word-at-a-time FNV-1a hash engine.
package fnvw_pkg;

	// FNV-1a 64-bit offset basis
	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	// FNV prime 0x100000001b3 split into a low 9-bit part and a single shifted one
	localparam logic [8:0] FNV_PRIME_LO  = 9'h1b3;
	localparam int unsigned FNV_PRIME_SHIFT = 40;

	// Byte counts and running total limits
	localparam logic [3:0]  FULL_BYTES = 4'd8;
	localparam logic [32:0] SEEN_MAX   = 33'h1_ffff_ffff;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MIX  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

FILE: rtl/fnvw_in_if.sv
// Input channel: one message word per beat with start, length, count and last marks.
interface fnvw_in_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [31:0] total_length;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last;

	modport source (
		output valid, start_req, total_length, data_word, byte_count, last,
		input  ready
	);
	modport sink (
		input  valid, start_req, total_length, data_word, byte_count, last,
		output ready
	);
endinterface

FILE: rtl/fnvw_out_if.sv
// Output channel: one folded hash and length error flag per beat.
interface fnvw_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;
	logic        length_error;

	modport source (
		output valid, hash_value, length_error,
		input  ready
	);
	modport sink (
		input  valid, hash_value, length_error,
		output ready
	);
endinterface

FILE: rtl/fnvw_mix_unit.sv
// Shared FNV-1a mix step: XOR an operand into the state, multiply by the FNV prime mod 2^64.
module fnvw_mix_unit (
	input  logic [63:0] hash,
	input  logic [63:0] operand,
	output logic [63:0] mixed
);

	logic [63:0] x;
	logic [72:0] lo_prod;

	// XOR the operand in
	assign x = hash ^ operand;

	// prime = 2^40 + 0x1b3: one narrow constant product plus one shifted copy
	assign lo_prod = x * fnvw_pkg::FNV_PRIME_LO;
	assign mixed = lo_prod[63:0] + (x << fnvw_pkg::FNV_PRIME_SHIFT);

endmodule

FILE: rtl/fnv1a_word_hash_engine_unit.sv
// Top level of the word-at-a-time FNV-1a 64-bit hash engine with 32-bit folded output.
//
// Messages arrive as 64-bit little-endian words on the item channel. A full word
// (byte_count of 8 or more) goes through the shared mix unit (XOR plus multiply by
// the FNV prime) whole after the accept cycle. A short word of n bytes is mixed
// byte by byte, since the same mix unit folds one byte per cycle; an empty word
// still makes an idle pass there. After an item with last set the engine loads
// the result register; if an earlier result is still waiting there, the engine
// holds until it is taken. The engine accepts no new item while a word is being
// mixed or a result waits to be loaded. The result is the 64-bit state XOR its
// upper half, low 32 bits, with a flag for a byte total that differs from the
// declared length, an oversized word, or a short word before the last one.
module fnv1a_word_hash_engine_unit (
	input  logic       clk,
	input  logic       arst_n,
	fnvw_in_if.sink    item,
	fnvw_out_if.source result
);

	fnvw_pkg::state_t state_q;

	logic [63:0] hash_q;
	logic [31:0] decl_len_q;
	logic [32:0] seen_q;
	logic        err_q;
	logic [63:0] word_q;
	logic        full_q;
	logic [3:0]  remain_q;
	logic        last_q;
	logic        res_valid_q;
	logic [31:0] res_hash_q;
	logic        res_err_q;

	logic        accept;
	logic        oversize;
	logic [3:0]  eff_count;
	logic        full_word;
	logic [32:0] seen_base;
	logic [33:0] seen_sum;
	logic [63:0] operand;
	logic [63:0] mixed;
	logic        emit_load;
	logic        final_err;

	// Accept only while the sequencer is idle
	assign item.ready = (state_q == fnvw_pkg::ST_IDLE);
	assign accept     = item.valid & item.ready;

	// Clamp oversized counts to a full word
	assign oversize  = item.byte_count > fnvw_pkg::FULL_BYTES;
	assign eff_count = oversize ? fnvw_pkg::FULL_BYTES : item.byte_count;
	assign full_word = (eff_count == fnvw_pkg::FULL_BYTES);

	// Saturating byte total
	assign seen_base = item.start_req ? 33'd0 : seen_q;
	assign seen_sum  = {1'b0, seen_base} + {30'd0, eff_count};

	// Full word goes in whole, tail bytes go in from the low byte
	assign operand = full_q ? word_q : {56'd0, word_q[7:0]};

	fnvw_mix_unit u_mix (
		.hash    (hash_q),
		.operand (operand),
		.mixed   (mixed)
	);

	// Load the result register when it is empty or being drained
	assign emit_load = (state_q == fnvw_pkg::ST_EMIT) & (~res_valid_q | result.ready);
	assign final_err = err_q | (seen_q != {1'b0, decl_len_q});

	// Sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fnvw_pkg::ST_IDLE;
			hash_q     <= '0;
			decl_len_q <= '0;
			seen_q     <= '0;
			err_q      <= 1'b0;
			full_q     <= 1'b0;
			remain_q   <= '0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				fnvw_pkg::ST_IDLE: begin
					if (accept) begin
						if (item.start_req) begin
							decl_len_q <= item.total_length;
							hash_q     <= fnvw_pkg::FNV_BASIS ^ {32'd0, item.total_length};
						end
						err_q <= (~item.start_req & err_q) | oversize |
							(~full_word & ~item.last);
						seen_q   <= seen_sum[33] ? fnvw_pkg::SEEN_MAX : seen_sum[32:0];
						full_q   <= full_word;
						remain_q <= full_word ? 4'd1 : eff_count;
						last_q   <= item.last;
						state_q  <= fnvw_pkg::ST_MIX;
					end
				end
				fnvw_pkg::ST_MIX: begin
					// One mix step per cycle until the count runs out
					if (remain_q != 4'd0) begin
						hash_q   <= mixed;
						remain_q <= remain_q - 4'd1;
					end
					if (remain_q <= 4'd1) begin
						state_q <= last_q ? fnvw_pkg::ST_EMIT : fnvw_pkg::ST_IDLE;
					end
				end
				fnvw_pkg::ST_EMIT: begin
					if (emit_load) begin
						state_q <= fnvw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fnvw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Word register: load on accept, advance one byte per tail step
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= item.data_word;
		end else if (state_q == fnvw_pkg::ST_MIX) begin
			word_q <= word_q >> 8;
		end
	end

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: fold the upper half into the lower half
	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_hash_q <= hash_q[31:0] ^ hash_q[63:32];
			res_err_q  <= final_err;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.hash_value   = res_hash_q;
	assign result.length_error = res_err_q;

endmodule
